@@ hw/rtl/cgsd_pkg.sv @@
// Shared types and constants for the charlieplexed greyscale scan driver.
package cgsd_pkg;

    localparam int GRID            = 10;
    localparam int LINES           = GRID + 1;
    localparam int BYTES_PER_PLANE = 2 * GRID;
    localparam int HALF_ROW        = 5;
    localparam int PIN_W           = 16;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 2 * PIN_W;

    localparam logic [7:0]       RESYNC_BYTE   = 8'h40;
    localparam logic [PIN_W-1:0] LOW_PIN_MASK  = 16'h001F;
    localparam logic [PIN_W-1:0] HIGH_PIN_MASK = 16'hfc00;

    typedef enum logic
    {
        REQ_TICK = 1'b0,
        REQ_BYTE = 1'b1
    } req_type_t;

    typedef logic [GRID-1:0] line_word_t;

endpackage

@@ hw/rtl/charlieplex_greyscale_scan_driver_top.sv @@
// Charlieplexed 10x10 LED matrix driver with bit-plane greyscale, frame store and scan.
// A scan tick beat is held in the input register, then its pin words are registered in the result
// register that drives the master side; a byte beat gives no result.
// Throughput: one beat per cycle on the slave side; the input stage stalls only while
// a finished result waits in the output register and the beat in the input register is a tick.
// Reset: the frame store, write position, scan position and output valid are all cleared;
// the repeat count loads the weight of plane zero.
module charlieplex_greyscale_scan_driver_top #(
    parameter int PLANES = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cgsd_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cgsd_pkg::OUT_DATA_W-1:0]   m_tdata    // [15:0] drive_enable, [31:16] drive_level
);
    import cgsd_pkg::*;

    localparam int PW       = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int REPEAT_W = PLANES;

    function automatic logic [REPEAT_W-1:0] plane_weight(input logic [PW-1:0] p);
        logic [REPEAT_W-1:0] top;
        top = REPEAT_W'(1) << (PLANES - 1);
        return top >> p;
    endfunction

    // Input stage.
    logic                  in_valid_reg;
    req_type_t             in_type_reg;
    logic [IN_DATA_W-1:0]  in_byte_reg;

    // Block state.
    line_word_t            store_reg  [PLANES][LINES];
    line_word_t            store_next [PLANES][LINES];
    logic [4:0]            byte_pos_reg, byte_pos_next;
    logic [PW-1:0]         wr_plane_reg, wr_plane_next;
    logic [PW-1:0]         scan_plane_reg, scan_plane_next;
    logic [REPEAT_W-1:0]   repeat_reg, repeat_next;
    logic [3:0]            scan_line_reg, scan_line_next;

    // Result stage.
    logic                  res_valid_reg, res_valid_next;
    logic [OUT_DATA_W-1:0] res_data_reg, res_data_next;

    logic                  fire;
    logic                  s_take;

    logic [3:0]            row;
    logic [3:0]            col_base;
    logic [3:0]            col;
    logic [3:0]            word_idx;
    line_word_t            cur_word;
    logic [3:0]            pin_pos;
    logic [PIN_W-1:0]      pin;
    logic [PIN_W-1:0]      enable;
    logic [PIN_W-1:0]      level;

    // A byte beat never needs the output register; a tick beat needs it free or draining.
    assign fire     = in_valid_reg && ((in_type_reg == REQ_BYTE) || !res_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_type_reg <= req_type_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    // Pin words for the current scan line.
    always_comb
    begin
        cur_word = store_reg[scan_plane_reg][scan_line_reg];
        pin_pos  = (scan_line_reg < 4'(HALF_ROW)) ? scan_line_reg : scan_line_reg + 4'(HALF_ROW);
        pin      = PIN_W'(1) << pin_pos;
        enable   = (PIN_W'(cur_word) & LOW_PIN_MASK)
                 | (HIGH_PIN_MASK & (PIN_W'(cur_word) << HALF_ROW))
                 | pin;
        // The diagonal line drives its pin high; every other line sinks through it.
        if (scan_line_reg == 4'(GRID))
        begin
            level = pin & enable;
        end
        else
        begin
            level = ~pin & enable;
        end
    end

    always_comb
    begin
        row      = byte_pos_reg[4:1];
        col_base = byte_pos_reg[0] ? 4'(HALF_ROW) : 4'd0;
        col      = 4'd0;
        word_idx = 4'd0;

        store_next      = store_reg;
        byte_pos_next   = byte_pos_reg;
        wr_plane_next   = wr_plane_reg;
        scan_plane_next = scan_plane_reg;
        repeat_next     = repeat_reg;
        scan_line_next  = scan_line_reg;
        res_valid_next  = res_valid_reg && !m_tready;
        res_data_next   = res_data_reg;

        if (fire)
        begin
            unique case (in_type_reg)
                REQ_BYTE:
                begin
                    if (in_byte_reg == RESYNC_BYTE)
                    begin
                        byte_pos_next = 5'd0;
                        wr_plane_next = '0;
                    end
                    else
                    begin
                        for (int i = 0; i < HALF_ROW; i++)
                        begin
                            col      = col_base + 4'(i);
                            word_idx = (col == row) ? 4'(GRID) : col;
                            store_next[wr_plane_reg][word_idx][row] = in_byte_reg[i];
                        end
                        if (byte_pos_reg == 5'(BYTES_PER_PLANE - 1))
                        begin
                            byte_pos_next = 5'd0;
                            wr_plane_next = (wr_plane_reg == PW'(PLANES - 1)) ?
                                            '0 : wr_plane_reg + PW'(1);
                        end
                        else
                        begin
                            byte_pos_next = byte_pos_reg + 5'd1;
                        end
                    end
                end
                REQ_TICK:
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = {level, enable};
                    if (scan_line_reg == 4'(LINES - 1))
                    begin
                        scan_line_next = 4'd0;
                        if (repeat_reg > REPEAT_W'(1))
                        begin
                            repeat_next = repeat_reg - REPEAT_W'(1);
                        end
                        else
                        begin
                            scan_plane_next = (scan_plane_reg == PW'(PLANES - 1)) ?
                                              '0 : scan_plane_reg + PW'(1);
                            repeat_next     = plane_weight(scan_plane_next);
                        end
                    end
                    else
                    begin
                        scan_line_next = scan_line_reg + 4'd1;
                    end
                end
                default:
                begin
                    res_valid_next = res_valid_reg && !m_tready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANES; p++)
            begin
                for (int w = 0; w < LINES; w++)
                begin
                    store_reg[p][w] <= '0;
                end
            end
            byte_pos_reg   <= 5'd0;
            wr_plane_reg   <= '0;
            scan_plane_reg <= '0;
            repeat_reg     <= plane_weight('0);
            scan_line_reg  <= 4'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            store_reg      <= store_next;
            byte_pos_reg   <= byte_pos_next;
            wr_plane_reg   <= wr_plane_next;
            scan_plane_reg <= scan_plane_next;
            repeat_reg     <= repeat_next;
            scan_line_reg  <= scan_line_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

endmodule

@@ hw/rtl/cgsd_checker.sv @@
// Port-level assertions for the scan driver, bound to the top level.
module cgsd_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [cgsd_pkg::IN_DATA_W-1:0]    s_tdata,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [cgsd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import cgsd_pkg::*;

    logic [PIN_W-1:0] enable;
    logic [PIN_W-1:0] level;

    assign enable = m_tdata[PIN_W-1:0];
    assign level  = m_tdata[OUT_DATA_W-1:PIN_W];

    // A waiting input beat is held by the source until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input beat changed while stalled");

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Pins 5 to 9 are never used by the matrix.
    a_unused_pins: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> enable[9:5] == 5'd0)
        else $error("unused pin enabled");

    // A pin is only driven high where it is enabled.
    a_level_masked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (level & ~enable) == '0)
        else $error("level set on a disabled pin");

    // Either the line pin sinks (level differs from enable) or only the diagonal pin is high.
    a_line_pin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (level != enable) || $onehot(level))
        else $error("line pin missing from result beat");

endmodule

bind charlieplex_greyscale_scan_driver_top cgsd_checker u_cgsd_checker (.*);
